@@ src/sta_pkg.sv @@
// ----------------------------------------------------------------------------
// Scancode translator package
// Types, scancode and character constants, and the US keymap tables for the
// translator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sta_pkg;

   typedef logic [7:0] scancode_type;
   typedef logic [6:0] char_type;
   typedef logic [2:0] seq_len_type;
   typedef logic [1:0] seq_idx_type;

   localparam int unsigned SeqDepth = 4;

   typedef struct packed {
      char_type [SeqDepth-1:0] chars;
      seq_len_type             len;
   } seq_type;

   typedef struct packed {
      seq_type seq;
      logic    shift_held;
      logic    ctrl_held;
   } dec_type;

   localparam scancode_type SC_LSHIFT_MAKE  = 8'h2A;
   localparam scancode_type SC_RSHIFT_MAKE  = 8'h36;
   localparam scancode_type SC_LSHIFT_BREAK = 8'hAA;
   localparam scancode_type SC_RSHIFT_BREAK = 8'hB6;
   localparam scancode_type SC_CTRL_MAKE    = 8'h1D;
   localparam scancode_type SC_CTRL_BREAK   = 8'h9D;
   localparam scancode_type SC_UP           = 8'h48;
   localparam scancode_type SC_DOWN         = 8'h50;
   localparam scancode_type SC_LEFT         = 8'h4B;
   localparam scancode_type SC_RIGHT        = 8'h4D;
   localparam scancode_type SC_HOME         = 8'h47;
   localparam scancode_type SC_END          = 8'h4F;
   localparam scancode_type SC_DELETE       = 8'h53;
   localparam scancode_type SC_KEY_C        = 8'h2E;
   localparam scancode_type SC_KEY_D        = 8'h20;
   localparam scancode_type SC_KEY_L        = 8'h26;

   localparam int unsigned ShiftRomDepth = 58;

   localparam char_type CH_NUL     = 7'h00;
   localparam char_type CH_ETX     = 7'h03;
   localparam char_type CH_EOT     = 7'h04;
   localparam char_type CH_FF      = 7'h0C;
   localparam char_type CH_ESC     = 7'h1B;
   localparam char_type CH_LBRACK  = 7'h5B;
   localparam char_type CH_THREE   = 7'h33;
   localparam char_type CH_TILDE   = 7'h7E;
   localparam char_type CH_UPPER_A = 7'h41;
   localparam char_type CH_UPPER_B = 7'h42;
   localparam char_type CH_UPPER_C = 7'h43;
   localparam char_type CH_UPPER_D = 7'h44;
   localparam char_type CH_UPPER_F = 7'h46;
   localparam char_type CH_UPPER_H = 7'h48;

   function automatic char_type plain_char(input logic [6:0] idx);
      char_type c;
      unique case (idx)
         7'd1:  c = 7'h1B;
         7'd2:  c = 7'h31;
         7'd3:  c = 7'h32;
         7'd4:  c = 7'h33;
         7'd5:  c = 7'h34;
         7'd6:  c = 7'h35;
         7'd7:  c = 7'h36;
         7'd8:  c = 7'h37;
         7'd9:  c = 7'h38;
         7'd10: c = 7'h39;
         7'd11: c = 7'h30;
         7'd12: c = 7'h2D;
         7'd13: c = 7'h3D;
         7'd14: c = 7'h08;
         7'd15: c = 7'h09;
         7'd16: c = 7'h71;
         7'd17: c = 7'h77;
         7'd18: c = 7'h65;
         7'd19: c = 7'h72;
         7'd20: c = 7'h74;
         7'd21: c = 7'h79;
         7'd22: c = 7'h75;
         7'd23: c = 7'h69;
         7'd24: c = 7'h6F;
         7'd25: c = 7'h70;
         7'd26: c = 7'h5B;
         7'd27: c = 7'h5D;
         7'd28: c = 7'h0A;
         7'd30: c = 7'h61;
         7'd31: c = 7'h73;
         7'd32: c = 7'h64;
         7'd33: c = 7'h66;
         7'd34: c = 7'h67;
         7'd35: c = 7'h68;
         7'd36: c = 7'h6A;
         7'd37: c = 7'h6B;
         7'd38: c = 7'h6C;
         7'd39: c = 7'h3B;
         7'd40: c = 7'h27;
         7'd41: c = 7'h60;
         7'd43: c = 7'h5C;
         7'd44: c = 7'h7A;
         7'd45: c = 7'h78;
         7'd46: c = 7'h63;
         7'd47: c = 7'h76;
         7'd48: c = 7'h62;
         7'd49: c = 7'h6E;
         7'd50: c = 7'h6D;
         7'd51: c = 7'h2C;
         7'd52: c = 7'h2E;
         7'd53: c = 7'h2F;
         7'd55: c = 7'h2A;
         7'd57: c = 7'h20;
         7'd74: c = 7'h2D;
         7'd78: c = 7'h2B;
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

   function automatic char_type shift_char(input logic [5:0] idx);
      char_type c;
      unique case (idx)
         6'd1:  c = 7'h1B;
         6'd2:  c = 7'h21;
         6'd3:  c = 7'h40;
         6'd4:  c = 7'h23;
         6'd5:  c = 7'h24;
         6'd6:  c = 7'h25;
         6'd7:  c = 7'h5E;
         6'd8:  c = 7'h26;
         6'd9:  c = 7'h2A;
         6'd10: c = 7'h28;
         6'd11: c = 7'h29;
         6'd12: c = 7'h5F;
         6'd13: c = 7'h2B;
         6'd14: c = 7'h08;
         6'd15: c = 7'h09;
         6'd16: c = 7'h51;
         6'd17: c = 7'h57;
         6'd18: c = 7'h45;
         6'd19: c = 7'h52;
         6'd20: c = 7'h54;
         6'd21: c = 7'h59;
         6'd22: c = 7'h55;
         6'd23: c = 7'h49;
         6'd24: c = 7'h4F;
         6'd25: c = 7'h50;
         6'd26: c = 7'h7B;
         6'd27: c = 7'h7D;
         6'd28: c = 7'h0A;
         6'd30: c = 7'h41;
         6'd31: c = 7'h53;
         6'd32: c = 7'h44;
         6'd33: c = 7'h46;
         6'd34: c = 7'h47;
         6'd35: c = 7'h48;
         6'd36: c = 7'h4A;
         6'd37: c = 7'h4B;
         6'd38: c = 7'h4C;
         6'd39: c = 7'h3A;
         6'd40: c = 7'h22;
         6'd41: c = 7'h7E;
         6'd43: c = 7'h7C;
         6'd44: c = 7'h5A;
         6'd45: c = 7'h58;
         6'd46: c = 7'h43;
         6'd47: c = 7'h56;
         6'd48: c = 7'h42;
         6'd49: c = 7'h4E;
         6'd50: c = 7'h4D;
         6'd51: c = 7'h3C;
         6'd52: c = 7'h3E;
         6'd53: c = 7'h3F;
         6'd55: c = 7'h2A;
         6'd57: c = 7'h20;
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

@@ src/sta_if.sv @@
// ----------------------------------------------------------------------------
// Scancode translator channels
// Valid/ready channels for scancode requests and character responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface sta_req_if;
   logic                  valid;
   logic                  ready;
   sta_pkg::scancode_type scancode;

   modport source (output valid, output scancode, input ready);
   modport sink   (input valid, input scancode, output ready);
endinterface

interface sta_rsp_if;
   logic              valid;
   logic              ready;
   sta_pkg::char_type char_code;
   logic              last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

`default_nettype wire

@@ src/sta_decode.sv @@
// ----------------------------------------------------------------------------
// Scancode decoder
// Maps one registered scancode and the modifier flags to a character sequence
// of up to four characters and the updated modifier flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sta_decode (
   input  sta_pkg::scancode_type scancode,
   input  logic                  shift_held,
   input  logic                  ctrl_held,
   output sta_pkg::dec_type      dec
);

   sta_pkg::char_type table_char;

   always_comb begin
      if (shift_held) begin
         table_char = (scancode < 8'(sta_pkg::ShiftRomDepth))
                    ? sta_pkg::shift_char(scancode[5:0]) : sta_pkg::CH_NUL;
      end else begin
         table_char = sta_pkg::plain_char(scancode[6:0]);
      end
   end

   always_comb begin
      dec.shift_held = shift_held;
      dec.ctrl_held  = ctrl_held;
      dec.seq.chars  = '0;
      dec.seq.len    = 3'd0;
      dec.seq.chars[0] = sta_pkg::CH_ESC;
      dec.seq.chars[1] = sta_pkg::CH_LBRACK;
      unique case (scancode)
         sta_pkg::SC_LSHIFT_MAKE, sta_pkg::SC_RSHIFT_MAKE:   dec.shift_held = 1'b1;
         sta_pkg::SC_LSHIFT_BREAK, sta_pkg::SC_RSHIFT_BREAK: dec.shift_held = 1'b0;
         sta_pkg::SC_CTRL_MAKE:  dec.ctrl_held = 1'b1;
         sta_pkg::SC_CTRL_BREAK: dec.ctrl_held = 1'b0;
         sta_pkg::SC_UP: begin
            dec.seq.chars[2] = sta_pkg::CH_UPPER_A;
            dec.seq.len      = 3'd3;
         end
         sta_pkg::SC_DOWN: begin
            dec.seq.chars[2] = sta_pkg::CH_UPPER_B;
            dec.seq.len      = 3'd3;
         end
         sta_pkg::SC_LEFT: begin
            dec.seq.chars[2] = sta_pkg::CH_UPPER_D;
            dec.seq.len      = 3'd3;
         end
         sta_pkg::SC_RIGHT: begin
            dec.seq.chars[2] = sta_pkg::CH_UPPER_C;
            dec.seq.len      = 3'd3;
         end
         sta_pkg::SC_HOME: begin
            dec.seq.chars[2] = sta_pkg::CH_UPPER_H;
            dec.seq.len      = 3'd3;
         end
         sta_pkg::SC_END: begin
            dec.seq.chars[2] = sta_pkg::CH_UPPER_F;
            dec.seq.len      = 3'd3;
         end
         sta_pkg::SC_DELETE: begin
            dec.seq.chars[2] = sta_pkg::CH_THREE;
            dec.seq.chars[3] = sta_pkg::CH_TILDE;
            dec.seq.len      = 3'd4;
         end
         default: begin
            if (!scancode[7]) begin
               if (ctrl_held && scancode == sta_pkg::SC_KEY_C) begin
                  dec.seq.chars[0] = sta_pkg::CH_ETX;
                  dec.seq.len      = 3'd1;
               end else if (ctrl_held && scancode == sta_pkg::SC_KEY_D) begin
                  dec.seq.chars[0] = sta_pkg::CH_EOT;
                  dec.seq.len      = 3'd1;
               end else if (ctrl_held && scancode == sta_pkg::SC_KEY_L) begin
                  dec.seq.chars[0] = sta_pkg::CH_FF;
                  dec.seq.len      = 3'd1;
               end else if (table_char != sta_pkg::CH_NUL) begin
                  dec.seq.chars[0] = table_char;
                  dec.seq.len      = 3'd1;
               end
            end
         end
      endcase
   end

endmodule

`default_nettype wire

@@ src/sta_sequencer.sv @@
// ----------------------------------------------------------------------------
// Response sequencer
// Holds one decoded character sequence and sends it one beat per character,
// flagging the final character.
// ----------------------------------------------------------------------------
`default_nettype none

module sta_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  sta_pkg::seq_type    seq,
   output logic                free,
   sta_rsp_if.source           rsp
);

   sta_pkg::char_type [sta_pkg::SeqDepth-1:0] chars_ff, chars_in;
   sta_pkg::seq_len_type                      len_ff, len_in;
   sta_pkg::seq_idx_type                      idx_ff, idx_in;
   logic                                      busy_ff, busy_in;
   logic                                      is_last;
   logic                                      beat;

   assign is_last       = (3'({1'b0, idx_ff}) + 3'd1) == len_ff;
   assign beat          = busy_ff && rsp.ready;
   assign free          = !busy_ff || (beat && is_last);
   assign rsp.valid     = busy_ff;
   assign rsp.char_code = chars_ff[idx_ff];
   assign rsp.last      = is_last;

   always_comb begin
      chars_in = chars_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      if (load && free) begin
         chars_in = seq.chars;
         len_in   = seq.len;
         idx_in   = '0;
         busy_in  = 1'b1;
      end else if (beat) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      chars_ff <= chars_in;
      len_ff   <= len_in;
   end

endmodule

`default_nettype wire

@@ src/scancode_to_ascii_translator.sv @@
// A scancode is registered on acceptance, then decoded and loaded into
// the response register once that is free, and its first character is offered.
// Throughput: one scancode per cycle while the response register is free; a
// scancode producing n characters holds it for n beats (up to four, set by escapes).
// Reset clears the shift and ctrl flags and empties both registers.
// ----------------------------------------------------------------------------
// Scancode to ASCII translator
// Set-1 keyboard scancodes in, US-layout ASCII characters and ANSI cursor
// sequences out.
// ----------------------------------------------------------------------------
`default_nettype none

module scancode_to_ascii_translator (
   input  logic      clock,
   input  logic      reset,
   sta_req_if.sink   req_chan,
   sta_rsp_if.source rsp_chan
);

   sta_pkg::scancode_type sc_ff, sc_in;
   logic                  sc_valid_ff, sc_valid_in;
   logic                  shift_ff, shift_in;
   logic                  ctrl_ff, ctrl_in;
   sta_pkg::dec_type      dec;
   logic                  seq_free;
   logic                  advance;
   logic                  load;

   sta_decode u_decode (
      .scancode   (sc_ff),
      .shift_held (shift_ff),
      .ctrl_held  (ctrl_ff),
      .dec        (dec)
   );

   sta_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .seq   (dec.seq),
      .free  (seq_free),
      .rsp   (rsp_chan)
   );

   assign advance        = sc_valid_ff && (dec.seq.len == 3'd0 || seq_free);
   assign load           = advance && dec.seq.len != 3'd0;
   assign req_chan.ready = !sc_valid_ff || advance;

   always_comb begin
      sc_in       = sc_ff;
      sc_valid_in = sc_valid_ff;
      shift_in    = shift_ff;
      ctrl_in     = ctrl_ff;
      if (advance) begin
         shift_in    = dec.shift_held;
         ctrl_in     = dec.ctrl_held;
         sc_valid_in = 1'b0;
      end
      if (req_chan.valid && req_chan.ready) begin
         sc_in       = req_chan.scancode;
         sc_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_valid_ff <= 1'b0;
         shift_ff    <= 1'b0;
         ctrl_ff     <= 1'b0;
      end else begin
         sc_valid_ff <= sc_valid_in;
         shift_ff    <= shift_in;
         ctrl_ff     <= ctrl_in;
      end
      sc_ff <= sc_in;
   end

   a_shift_make_sets_flag : assert property (@(posedge clock) disable iff (reset)
      (advance && (sc_ff == sta_pkg::SC_LSHIFT_MAKE || sc_ff == sta_pkg::SC_RSHIFT_MAKE))
      |=> shift_ff)
      else $error("Shift make did not set the shift flag.");

   a_load_only_when_free : assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_chan.valid || (rsp_chan.ready && rsp_chan.last)))
      else $error("Sequence loaded over an unfinished response.");

   a_load_gives_beat : assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_chan.valid)
      else $error("Loaded sequence not offered on the response channel.");

   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !sc_valid_ff |-> req_chan.ready)
      else $error("Empty input register refused a beat.");

endmodule

`default_nettype wire

@@ tb/sv/tb_scancode_to_ascii_translator.sv @@
// ----------------------------------------------------------------------------
// Scancode to ASCII translator testbench
// Sends set-1 scancodes through the request channel and checks every
// character beat against a model of the US keymap, the shift and ctrl flags
// and the cursor escape sequences. A short table of directed codes comes
// first, then random typing under three patterns of idling on both channels.
// ----------------------------------------------------------------------------

module tb_scancode_to_ascii_translator;
   timeunit 1ns;
   timeprecision 1ps;

   import sta_pkg::*;

   localparam int unsigned RandomPerPhase = 131;
   localparam int unsigned QuietLimit     = 2000;
   localparam int unsigned TailCycles     = 10;

   localparam scancode_type SC_KP_MINUS  = 8'h4A;
   localparam scancode_type SC_KP_PLUS   = 8'h4E;
   localparam scancode_type SC_KEY_A     = 8'h1E;
   localparam scancode_type SC_KEY_Q     = 8'h10;
   localparam char_type     KEYPAD_MINUS = 7'h2D;
   localparam char_type     KEYPAD_PLUS  = 7'h2B;
   localparam char_type     CH_LOWER_A   = 7'h61;

   typedef struct packed {
      logic [2:0]          count;
      char_type [3:0]      chars;
   } char_burst_type;

   typedef struct packed {
      char_type char_code;
      logic     last;
   } char_beat_type;

   typedef struct packed {
      scancode_type   sc;
      logic           typed;
      char_burst_type burst;
   } key_row_type;

   logic clock = 1'b0;
   logic reset;

   sta_req_if req_chan ();
   sta_rsp_if rsp_chan ();

   scancode_to_ascii_translator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   char_type plain_keys [0:57] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

   char_type shifted_keys [0:57] = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
   };

   scancode_type cursor_codes [0:6] = '{
      SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT, SC_HOME, SC_END, SC_DELETE
   };

   scancode_type modifier_codes [0:5] = '{
      SC_LSHIFT_MAKE, SC_RSHIFT_MAKE, SC_LSHIFT_BREAK, SC_RSHIFT_BREAK,
      SC_CTRL_MAKE, SC_CTRL_BREAK
   };

   scancode_type ctrl_letter_codes [0:2] = '{SC_KEY_C, SC_KEY_D, SC_KEY_L};

   key_row_type key_rows [0:26] = '{
      '{SC_KEY_A,        1'b1, '{3'd1, {CH_NUL, CH_NUL, CH_NUL, CH_LOWER_A}}},
      '{8'h00,           1'b1, '{3'd0, {4{CH_NUL}}}},
      '{8'hFF,           1'b1, '{3'd0, {4{CH_NUL}}}},
      '{8'h7F,           1'b1, '{3'd0, {4{CH_NUL}}}},
      '{SC_UP,           1'b1, '{3'd3, {CH_NUL, CH_UPPER_A, CH_LBRACK, CH_ESC}}},
      '{SC_DOWN,         1'b1, '{3'd3, {CH_NUL, CH_UPPER_B, CH_LBRACK, CH_ESC}}},
      '{SC_LEFT,         1'b1, '{3'd3, {CH_NUL, CH_UPPER_D, CH_LBRACK, CH_ESC}}},
      '{SC_RIGHT,        1'b1, '{3'd3, {CH_NUL, CH_UPPER_C, CH_LBRACK, CH_ESC}}},
      '{SC_HOME,         1'b1, '{3'd3, {CH_NUL, CH_UPPER_H, CH_LBRACK, CH_ESC}}},
      '{SC_END,          1'b1, '{3'd3, {CH_NUL, CH_UPPER_F, CH_LBRACK, CH_ESC}}},
      '{SC_DELETE,       1'b1, '{3'd4, {CH_TILDE, CH_THREE, CH_LBRACK, CH_ESC}}},
      '{SC_KP_MINUS,     1'b0, '{3'd0, {4{CH_NUL}}}},
      '{SC_KP_PLUS,      1'b0, '{3'd0, {4{CH_NUL}}}},
      '{SC_LSHIFT_MAKE,  1'b0, '{3'd0, {4{CH_NUL}}}},
      '{SC_KEY_A,        1'b0, '{3'd0, {4{CH_NUL}}}},
      '{SC_KP_MINUS,     1'b0, '{3'd0, {4{CH_NUL}}}},
      '{SC_UP,           1'b0, '{3'd0, {4{CH_NUL}}}},
      '{SC_LSHIFT_BREAK, 1'b0, '{3'd0, {4{CH_NUL}}}},
      '{SC_RSHIFT_MAKE,  1'b0, '{3'd0, {4{CH_NUL}}}},
      '{SC_CTRL_MAKE,    1'b0, '{3'd0, {4{CH_NUL}}}},
      '{SC_KEY_C,        1'b0, '{3'd0, {4{CH_NUL}}}},
      '{SC_KEY_D,        1'b0, '{3'd0, {4{CH_NUL}}}},
      '{SC_KEY_L,        1'b0, '{3'd0, {4{CH_NUL}}}},
      '{SC_KEY_Q,        1'b0, '{3'd0, {4{CH_NUL}}}},
      '{SC_CTRL_BREAK,   1'b0, '{3'd0, {4{CH_NUL}}}},
      '{SC_RSHIFT_BREAK, 1'b0, '{3'd0, {4{CH_NUL}}}},
      '{SC_KEY_C,        1'b0, '{3'd0, {4{CH_NUL}}}}
   };

   logic          shift_down;
   logic          ctrl_down;
   char_beat_type pending_chars [$];
   char_beat_type expected_beat;
   int unsigned   send_idle_pct;
   int unsigned   recv_idle_pct;
   int unsigned   scancodes_sent;
   int unsigned   chars_checked  = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   quiet_cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic char_burst_type decode_scancode(input scancode_type sc);
      char_burst_type burst;
      char_type       esc_final;
      char_type       c;
      burst     = '0;
      esc_final = CH_NUL;
      c         = CH_NUL;
      case (sc)
         SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:   shift_down = 1'b1;
         SC_LSHIFT_BREAK, SC_RSHIFT_BREAK: shift_down = 1'b0;
         SC_CTRL_MAKE:                     ctrl_down  = 1'b1;
         SC_CTRL_BREAK:                    ctrl_down  = 1'b0;
         SC_UP:                            esc_final  = CH_UPPER_A;
         SC_DOWN:                          esc_final  = CH_UPPER_B;
         SC_LEFT:                          esc_final  = CH_UPPER_D;
         SC_RIGHT:                         esc_final  = CH_UPPER_C;
         SC_HOME:                          esc_final  = CH_UPPER_H;
         SC_END:                           esc_final  = CH_UPPER_F;
         SC_DELETE: begin
            burst = '{3'd4, {CH_TILDE, CH_THREE, CH_LBRACK, CH_ESC}};
         end
         default: begin
            if (!sc[7]) begin
               if (ctrl_down && sc == SC_KEY_C) c = CH_ETX;
               else if (ctrl_down && sc == SC_KEY_D) c = CH_EOT;
               else if (ctrl_down && sc == SC_KEY_L) c = CH_FF;
               else if (shift_down) c = (sc < ShiftRomDepth) ? shifted_keys[sc] : CH_NUL;
               else if (sc < ShiftRomDepth) c = plain_keys[sc];
               else if (sc == SC_KP_MINUS) c = KEYPAD_MINUS;
               else if (sc == SC_KP_PLUS) c = KEYPAD_PLUS;
               if (c != CH_NUL) burst = '{3'd1, {CH_NUL, CH_NUL, CH_NUL, c}};
            end
         end
      endcase
      if (esc_final != CH_NUL) burst = '{3'd3, {CH_NUL, esc_final, CH_LBRACK, CH_ESC}};
      return burst;
   endfunction

   function automatic void queue_chars(input char_burst_type burst);
      for (int k = 0; k < burst.count; k++) begin
         pending_chars.push_back('{burst.chars[k], k == burst.count - 1});
      end
   endfunction

   function automatic scancode_type random_scancode();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 40) return scancode_type'($urandom_range(8'h01, 8'h39));
      if (pick < 52) return {1'b1, 7'($urandom_range(8'h01, 8'h58))};
      if (pick < 64) return cursor_codes[$urandom_range(6)];
      if (pick < 82) return modifier_codes[$urandom_range(5)];
      if (pick < 88) return ctrl_letter_codes[$urandom_range(2)];
      if (pick < 93) return scancode_type'($urandom_range(8'h37, 8'h58));
      return scancode_type'($urandom_range(255));
   endfunction

   // Returns at the rising edge at which the scancode beat is taken.
   task automatic send_scancode(input scancode_type sc);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.scancode <= sc;
      do begin
         @(negedge clock);
         taken = req_chan.ready;
         @(posedge clock);
      end while (!taken);
      scancodes_sent++;
   endtask

   task automatic drain_chars();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_chars.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(negedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected beat, expected none, got char_code %h last %b",
                        $time, rsp_chan.char_code, rsp_chan.last);
            end else begin
               expected_beat = pending_chars.pop_front();
               if (rsp_chan.char_code !== expected_beat.char_code) begin
                  mismatch_count++;
                  $display("%0t: char_code expected %h, got %h",
                           $time, expected_beat.char_code, rsp_chan.char_code);
               end
               if (rsp_chan.last !== expected_beat.last) begin
                  mismatch_count++;
                  $display("%0t: last expected %b, got %b",
                           $time, expected_beat.last, rsp_chan.last);
               end
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QuietLimit) begin
            $display("%0t: no beat for %0d cycles, %0d characters outstanding",
                     $time, QuietLimit, pending_chars.size());
            $display("*** FAILED ***");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      char_burst_type predicted;
      scancode_type   sc_pick;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.scancode <= '0;
      shift_down     = 1'b0;
      ctrl_down      = 1'b0;
      scancodes_sent = 0;
      send_idle_pct  = 12;
      recv_idle_pct  = 60;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (key_rows[i]) begin
         send_scancode(key_rows[i].sc);
         predicted = decode_scancode(key_rows[i].sc);
         queue_chars(key_rows[i].typed ? key_rows[i].burst : predicted);
      end
      drain_chars();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 60 : 0;
         recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 12 : 0;
         for (int n = 0; n < RandomPerPhase; n++) begin
            sc_pick = random_scancode();
            send_scancode(sc_pick);
            queue_chars(decode_scancode(sc_pick));
         end
         drain_chars();
      end
      repeat (TailCycles) @(posedge clock);

      $display("Sent %0d scancodes: a directed table of %0d, then random typing", scancodes_sent,
               $size(key_rows));
      $display("under three idling patterns; %0d character beats checked, %0d mismatches.",
               chars_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/sta_pkg.sv
src/sta_if.sv
src/sta_decode.sv
src/sta_sequencer.sv
src/scancode_to_ascii_translator.sv
tb/sv/tb_scancode_to_ascii_translator.sv
